FILE: src/usb_ets_pkg.sv
// usb_ets_pkg: shared types and constants of the endpoint transfer sequencer
// no dependencies; imported by every module of the block
package usb_ets_pkg;

    localparam int NUM_ENDPOINTS = 8;
    localparam int MAX_PACKET    = 64;
    localparam int EP_W          = 3;
    localparam int LEN_W         = 16;
    localparam int CNT_W         = LEN_W + 1;
    localparam int DONE_W        = 10;
    localparam int ADDR_W        = 7;
    localparam int PKT_W         = 7;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        CMD_START     = 3'd0,
        CMD_IN_DONE   = 3'd1,
        CMD_OUT_DONE  = 3'd2,
        CMD_SET_ADDR  = 3'd3,
        CMD_STATUS    = 3'd4,
        CMD_BUS_RESET = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        ACT_IN     = 3'd0,
        ACT_IN_ZLP = 3'd1,
        ACT_OUT    = 3'd2,
        ACT_DONE   = 3'd3,
        ACT_ADDR   = 3'd4
    } act_t;

    typedef enum logic [2:0] {
        OP_START,
        OP_IN_DONE,
        OP_OUT_DONE,
        OP_SET_ADDR,
        OP_STATUS,
        OP_BUS_RESET
    } op_kind_t;

    // classified event as it travels from front to back
    typedef struct packed {
        op_kind_t              kind;
        logic [EP_W-1:0]       ep;
        logic                  dir_in;
        logic [LEN_W-1:0]      tlen;
        logic [DONE_W-1:0]     done;
        logic [ADDR_W-1:0]     addr;
    } op_t;

    // queue status seen by the front
    typedef struct packed {
        logic push;
        logic full;
    } q_wr_t;

    // queue status seen by the back
    typedef struct packed {
        logic pop;
        logic avail;
    } q_rd_t;

endpackage

FILE: src/usb_ets_if.sv
// usb_ets_evt_if / usb_ets_act_if: valid-ready channels of the sequencer
// no dependencies
interface usb_ets_evt_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [2:0]  endpoint;
    logic        direction_in;
    logic [15:0] transfer_length;
    logic [9:0]  bytes_done;
    logic [6:0]  new_address;

    modport source (output valid, cmd, endpoint, direction_in, transfer_length,
                    bytes_done, new_address, input ready);
    modport sink   (input valid, cmd, endpoint, direction_in, transfer_length,
                    bytes_done, new_address, output ready);
    modport monitor (input valid, ready, cmd, endpoint, direction_in,
                     transfer_length, bytes_done, new_address);
endinterface

interface usb_ets_act_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [2:0]  result_endpoint;
    logic [15:0] packet_offset;
    logic [6:0]  packet_length;
    logic [6:0]  address_value;

    modport source (output valid, action, result_endpoint, packet_offset,
                    packet_length, address_value, input ready);
    modport sink   (input valid, action, result_endpoint, packet_offset,
                    packet_length, address_value, output ready);
    modport monitor (input valid, ready, action, result_endpoint, packet_offset,
                     packet_length, address_value);
endinterface

FILE: src/usb_ets_front.sv
// usb_ets_front: accepts endpoint events, classifies them, drops unused codes
// depends on usb_ets_pkg and usb_ets_evt_if
module usb_ets_front (
    usb_ets_evt_if.sink         events,
    input  logic                q_full,
    output usb_ets_pkg::q_wr_t  q_wr,
    output usb_ets_pkg::op_t    q_op
);
    import usb_ets_pkg::*;

    logic keep;

    assign events.ready = !q_full;

    always_comb
    begin
        keep         = 1'b1;
        q_op.kind    = OP_START;
        q_op.ep      = events.endpoint;
        q_op.dir_in  = events.direction_in;
        q_op.tlen    = events.transfer_length;
        q_op.done    = events.bytes_done;
        q_op.addr    = events.new_address;
        unique case (events.cmd)
            CMD_START:     q_op.kind = OP_START;
            CMD_IN_DONE:   q_op.kind = OP_IN_DONE;
            CMD_OUT_DONE:  q_op.kind = OP_OUT_DONE;
            // control requests always concern endpoint 0
            CMD_SET_ADDR:
            begin
                q_op.kind = OP_SET_ADDR;
                q_op.ep   = '0;
            end
            CMD_STATUS:
            begin
                q_op.kind = OP_STATUS;
                q_op.ep   = '0;
            end
            CMD_BUS_RESET:
            begin
                q_op.kind = OP_BUS_RESET;
                q_op.ep   = '0;
            end
            default:       keep = 1'b0;
        endcase
        if (int'(q_op.ep) >= NUM_ENDPOINTS)
            keep = 1'b0;
    end

    assign q_wr.full = q_full;
    assign q_wr.push = events.valid && events.ready && keep;

endmodule

FILE: src/usb_ets_queue.sv
// usb_ets_queue: short fifo of classified events between front and back
// depends on usb_ets_pkg
module usb_ets_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  usb_ets_pkg::q_wr_t  wr,
    input  usb_ets_pkg::op_t    wr_op,
    output logic                full,
    input  usb_ets_pkg::q_rd_t  rd,
    output logic                avail,
    output usb_ets_pkg::op_t    rd_op
);
    import usb_ets_pkg::*;

    op_t               mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_push, do_pop;

    assign full    = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign avail   = (count_reg != '0);
    assign rd_op   = mem[rd_ptr_reg];
    assign do_push = wr.push && !wr.full;
    assign do_pop  = rd.pop && rd.avail;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= wr_op;
    end

endmodule

FILE: src/usb_ets_back.sv
// usb_ets_back: per-endpoint transfer state, packet arming and result register
// depends on usb_ets_pkg and usb_ets_act_if
module usb_ets_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_avail,
    input  usb_ets_pkg::op_t    op,
    output usb_ets_pkg::q_rd_t  q_rd,
    usb_ets_act_if.source       actions
);
    import usb_ets_pkg::*;

    logic [LEN_W-1:0]  size_reg  [NUM_ENDPOINTS];
    logic [CNT_W-1:0]  count_reg [NUM_ENDPOINTS];
    logic [NUM_ENDPOINTS-1:0] busy_reg, zlp_reg, dir_reg;
    logic              pend_reg, pend_next;
    logic [ADDR_W-1:0] dev_addr_reg, dev_addr_next;

    logic              valid_reg;
    act_t              act_reg, act_next;
    logic [EP_W-1:0]   ep_reg;
    logic [LEN_W-1:0]  off_reg, off_next;
    logic [PKT_W-1:0]  len_reg, len_next;
    logic [ADDR_W-1:0] adr_reg, adr_next;

    logic              pop, emit;
    logic [EP_W-1:0]   e;
    logic [LEN_W-1:0]  v_size;
    logic [CNT_W-1:0]  v_count, v_diff;
    logic              v_busy, v_zlp, v_dir, was_in;
    logic              run_in, run_out, run_fin;

    assign pop        = q_avail && (!valid_reg || actions.ready);
    assign q_rd.pop   = pop;
    assign q_rd.avail = q_avail;
    assign e          = op.ep;
    assign v_diff     = {1'b0, v_size} - v_count;

    always_comb
    begin
        v_size        = size_reg[e];
        v_count       = count_reg[e];
        v_busy        = busy_reg[e];
        v_zlp         = zlp_reg[e];
        v_dir         = dir_reg[e];
        pend_next     = pend_reg;
        dev_addr_next = dev_addr_reg;
        run_in        = 1'b0;
        run_out       = 1'b0;
        run_fin       = 1'b0;
        was_in        = 1'b0;
        emit          = 1'b0;
        act_next      = ACT_DONE;
        off_next      = '0;
        len_next      = '0;
        adr_next      = '0;

        unique case (op.kind)
            OP_BUS_RESET:
            begin
                dev_addr_next = '0;
                pend_next     = 1'b0;
                v_busy        = 1'b0;
                v_zlp         = 1'b0;
                v_dir         = 1'b0;
                v_size        = '0;
            end
            OP_SET_ADDR, OP_STATUS:
            begin
                if (!busy_reg[0])
                begin
                    if (op.kind == OP_SET_ADDR)
                    begin
                        dev_addr_next = op.addr;
                        pend_next     = 1'b1;
                    end
                    v_count = '0;
                    v_size  = '0;
                    v_busy  = 1'b1;
                    v_zlp   = 1'b1;
                    v_dir   = 1'b1;
                    run_in  = 1'b1;
                end
            end
            OP_START:
            begin
                v_count = '0;
                v_size  = op.tlen;
                v_busy  = 1'b1;
                if (op.tlen == '0)
                    v_zlp = 1'b1;
                if (op.dir_in)
                begin
                    v_dir  = 1'b1;
                    run_in = 1'b1;
                end
                else
                    run_out = 1'b1;
            end
            OP_IN_DONE:
            begin
                if (v_busy && v_dir)
                begin
                    v_count = v_count + CNT_W'(op.done);
                    run_in  = 1'b1;
                end
            end
            OP_OUT_DONE:
            begin
                if (v_busy && !v_dir)
                    run_out = 1'b1;
            end
            default: ;
        endcase

        if (run_in)
        begin
            if (v_count < {1'b0, v_size})
            begin
                emit     = 1'b1;
                act_next = ACT_IN;
                off_next = v_count[LEN_W-1:0];
                len_next = (v_diff > CNT_W'(MAX_PACKET)) ? PKT_W'(MAX_PACKET)
                                                          : v_diff[PKT_W-1:0];
            end
            else if (v_zlp)
            begin
                v_zlp    = 1'b0;
                emit     = 1'b1;
                act_next = ACT_IN_ZLP;
            end
            else
                run_fin = 1'b1;
        end

        if (run_out)
        begin
            if (v_size != '0)
            begin
                emit     = 1'b1;
                act_next = ACT_OUT;
                len_next = PKT_W'(MAX_PACKET);
            end
            else if (v_zlp)
            begin
                v_zlp    = 1'b0;
                v_busy   = 1'b0;
                emit     = 1'b1;
                act_next = ACT_OUT;
                len_next = PKT_W'(MAX_PACKET);
            end
            else
                run_fin = 1'b1;
        end

        if (run_fin)
        begin
            was_in = v_dir;
            v_dir  = 1'b0;
            v_zlp  = 1'b0;
            v_busy = 1'b0;
            emit   = 1'b1;
            priority if (e != '0)
                act_next = ACT_DONE;
            else if (pend_reg)
            begin
                pend_next = 1'b0;
                if (dev_addr_next != '0)
                begin
                    act_next = ACT_ADDR;
                    adr_next = dev_addr_next;
                end
            end
            else if (was_in && v_size != '0)
            begin
                // status stage of a control read: zero-length OUT, armed and released
                v_count  = '0;
                v_size   = '0;
                act_next = ACT_OUT;
                len_next = PKT_W'(MAX_PACKET);
            end
            else
                act_next = ACT_DONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ENDPOINTS; i++)
            begin
                size_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
            busy_reg     <= '0;
            zlp_reg      <= '0;
            dir_reg      <= '0;
            pend_reg     <= 1'b0;
            dev_addr_reg <= '0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                size_reg[e]  <= v_size;
                count_reg[e] <= v_count;
                busy_reg[e]  <= v_busy;
                zlp_reg[e]   <= v_zlp;
                dir_reg[e]   <= v_dir;
                pend_reg     <= pend_next;
                dev_addr_reg <= dev_addr_next;
            end
            if (pop && emit)
                valid_reg <= 1'b1;
            else if (actions.ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && emit)
        begin
            act_reg <= act_next;
            ep_reg  <= e;
            off_reg <= off_next;
            len_reg <= len_next;
            adr_reg <= adr_next;
        end
    end

    assign actions.valid           = valid_reg;
    assign actions.action          = act_reg;
    assign actions.result_endpoint = ep_reg;
    assign actions.packet_offset   = off_reg;
    assign actions.packet_length   = len_reg;
    assign actions.address_value   = adr_reg;

endmodule

FILE: src/usb_endpoint_transfer_sequencer_core.sv
// channel   | role   | carries
// events    | sink   | cmd, endpoint, direction_in, transfer_length, bytes_done, new_address
// actions   | source | action, result_endpoint, packet_offset, packet_length, address_value
//
// one event is taken per cycle while the four-entry queue has room
// the back retires one queued event per cycle when its result register is free or being taken
// with an empty queue, an accepted event is written into a queue entry, then popped into the result register
// ignored events give no result
// rst_n clears queue, per-endpoint state, address and result valid at once
// a stall on actions fills the queue, then drops events.ready
// depends on usb_ets_pkg, usb_ets_if, usb_ets_front, usb_ets_queue, usb_ets_back
module usb_endpoint_transfer_sequencer_core (
    input  logic          clk,
    input  logic          rst_n,
    usb_ets_evt_if.sink   events,
    usb_ets_act_if.source actions
);
    import usb_ets_pkg::*;

    q_wr_t q_wr;
    q_rd_t q_rd;
    op_t   wr_op, rd_op;
    logic  q_full, q_avail;

    usb_ets_front u_front (
        .events (events),
        .q_full (q_full),
        .q_wr   (q_wr),
        .q_op   (wr_op)
    );

    usb_ets_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_wr),
        .wr_op (wr_op),
        .full  (q_full),
        .rd    (q_rd),
        .avail (q_avail),
        .rd_op (rd_op)
    );

    usb_ets_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_avail (q_avail),
        .op      (rd_op),
        .q_rd    (q_rd),
        .actions (actions)
    );

endmodule

FILE: src/usb_ets_checker.sv
// usb_ets_checker: port-level checks of the sequencer, bound to the top level
// depends on usb_ets_pkg and the top level's actions channel
module usb_ets_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       valid,
    input logic       ready,
    input logic [2:0] action,
    input logic [2:0] result_endpoint,
    input logic [15:0] packet_offset,
    input logic [6:0] packet_length,
    input logic [6:0] address_value
);
    import usb_ets_pkg::*;

    // no result may be offered during reset
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |-> !valid)
        else $error("result valid during reset");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable(action))
        else $error("stalled result changed");

    a_in_len: assert property (@(posedge clk) disable iff (!rst_n)
        valid && action == ACT_IN |->
            packet_length != '0 && packet_length <= PKT_W'(MAX_PACKET))
        else $error("armed IN packet length out of range");

    // address is only applied on endpoint 0, and never as address 0
    a_addr: assert property (@(posedge clk) disable iff (!rst_n)
        valid && action == ACT_ADDR |->
            result_endpoint == '0 && address_value != '0)
        else $error("bad apply address result");

    a_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
        valid && action != ACT_IN |->
            packet_offset == '0)
        else $error("offset set on non IN action");

endmodule

bind usb_endpoint_transfer_sequencer_core usb_ets_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .valid           (actions.valid),
    .ready           (actions.ready),
    .action          (actions.action),
    .result_endpoint (actions.result_endpoint),
    .packet_offset   (actions.packet_offset),
    .packet_length   (actions.packet_length),
    .address_value   (actions.address_value)
);

FILE: dv/tb_top.sv
// tb_top: randomized self-checking bench for usb_endpoint_transfer_sequencer_core
// depends on usb_ets_pkg, usb_ets_if and the core; has its own transfer-state predictor
`timescale 1ns / 100ps

module tb_top;
    import usb_ets_pkg::*;

    localparam logic [2:0] CMD_RSVD_A = 3'd6;
    localparam logic [2:0] CMD_RSVD_B = 3'd7;
    localparam int RANDOM_ITEMS = 650;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 16;

    typedef struct packed {
        logic [2:0]        cmd;
        logic [EP_W-1:0]   ep;
        logic              dir_in;
        logic [LEN_W-1:0]  tlen;
        logic [DONE_W-1:0] done;
        logic [ADDR_W-1:0] addr;
    } usb_evt_t;

    typedef struct packed {
        act_t              action;
        logic [EP_W-1:0]   ep;
        logic [LEN_W-1:0]  offset;
        logic [PKT_W-1:0]  length;
        logic [ADDR_W-1:0] addr;
    } usb_action_t;

    logic clk;
    logic rst_n;

    usb_ets_evt_if events_if ();
    usb_ets_act_if actions_if ();

    usb_endpoint_transfer_sequencer_core uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .events  (events_if),
        .actions (actions_if)
    );

    usb_evt_t    event_backlog [$];
    usb_action_t pending_actions [$];
    usb_evt_t    offered;
    int unsigned src_wait;
    int unsigned sink_wait;
    int unsigned hold_left;
    bit          hold_armed;
    int unsigned events_taken;
    int unsigned fail_count;
    int unsigned queued_count;

    // predicted endpoint state
    logic [LEN_W-1:0]  ep_size  [NUM_ENDPOINTS];
    logic [CNT_W-1:0]  ep_count [NUM_ENDPOINTS];
    logic              ep_busy  [NUM_ENDPOINTS];
    logic              ep_zlp   [NUM_ENDPOINTS];
    logic              ep_in    [NUM_ENDPOINTS];
    logic              addr_pending;
    logic [ADDR_W-1:0] dev_addr;

    function automatic usb_action_t act_of(act_t a, logic [EP_W-1:0] ep,
                                           logic [LEN_W-1:0] off, logic [PKT_W-1:0] len,
                                           logic [ADDR_W-1:0] adr);
        usb_action_t r;
        r.action = a;
        r.ep     = ep;
        r.offset = off;
        r.length = len;
        r.addr   = adr;
        return r;
    endfunction

    function automatic usb_action_t close_transfer(logic [EP_W-1:0] ep);
        logic was_in;
        was_in      = ep_in[ep];
        ep_in[ep]   = 1'b0;
        ep_zlp[ep]  = 1'b0;
        ep_busy[ep] = 1'b0;
        if (ep != 0)
            return act_of(ACT_DONE, ep, '0, '0, '0);
        if (addr_pending) begin
            addr_pending = 1'b0;
            if (dev_addr != 0)
                return act_of(ACT_ADDR, '0, '0, '0, dev_addr);
            return act_of(ACT_DONE, '0, '0, '0, '0);
        end
        if (was_in && ep_size[0] != 0) begin
            // zero-length OUT status stage: armed and released in the same step
            ep_count[0] = '0;
            ep_size[0]  = '0;
            return act_of(ACT_OUT, '0, '0, PKT_W'(MAX_PACKET), '0);
        end
        return act_of(ACT_DONE, '0, '0, '0, '0);
    endfunction

    function automatic usb_action_t next_in_packet(logic [EP_W-1:0] ep);
        logic [CNT_W-1:0] left;
        if (ep_count[ep] < {1'b0, ep_size[ep]}) begin
            left = {1'b0, ep_size[ep]} - ep_count[ep];
            if (left > MAX_PACKET)
                left = CNT_W'(MAX_PACKET);
            return act_of(ACT_IN, ep, ep_count[ep][LEN_W-1:0], left[PKT_W-1:0], '0);
        end
        if (ep_zlp[ep]) begin
            ep_zlp[ep] = 1'b0;
            return act_of(ACT_IN_ZLP, ep, '0, '0, '0);
        end
        return close_transfer(ep);
    endfunction

    function automatic usb_action_t next_out_receive(logic [EP_W-1:0] ep);
        if (ep_size[ep] != 0)
            return act_of(ACT_OUT, ep, '0, PKT_W'(MAX_PACKET), '0);
        if (ep_zlp[ep]) begin
            ep_zlp[ep]  = 1'b0;
            ep_busy[ep] = 1'b0;
            return act_of(ACT_OUT, ep, '0, PKT_W'(MAX_PACKET), '0);
        end
        return close_transfer(ep);
    endfunction

    // flags are only ever set here, a stale IN direction survives a restart
    function automatic usb_action_t begin_transfer(logic [EP_W-1:0] ep, logic dir_in,
                                                   logic [LEN_W-1:0] len);
        ep_count[ep] = '0;
        ep_size[ep]  = len;
        ep_busy[ep]  = 1'b1;
        if (len == 0)
            ep_zlp[ep] = 1'b1;
        if (dir_in) begin
            ep_in[ep] = 1'b1;
            return next_in_packet(ep);
        end
        return next_out_receive(ep);
    endfunction

    function automatic bit sequence_event(usb_evt_t e, output usb_action_t r);
        case (e.cmd)
            CMD_BUS_RESET: begin
                dev_addr     = '0;
                addr_pending = 1'b0;
                ep_busy[0]   = 1'b0;
                ep_zlp[0]    = 1'b0;
                ep_in[0]     = 1'b0;
                ep_size[0]   = '0;
                return 1'b0;
            end
            CMD_SET_ADDR, CMD_STATUS: begin
                if (ep_busy[0])
                    return 1'b0;
                if (e.cmd == CMD_SET_ADDR) begin
                    dev_addr     = e.addr;
                    addr_pending = 1'b1;
                end
                r = begin_transfer('0, 1'b1, '0);
                return 1'b1;
            end
            CMD_START: begin
                r = begin_transfer(e.ep, e.dir_in, e.tlen);
                return 1'b1;
            end
            CMD_IN_DONE: begin
                if (!ep_busy[e.ep] || !ep_in[e.ep])
                    return 1'b0;
                ep_count[e.ep] = ep_count[e.ep] + CNT_W'(e.done);
                r = next_in_packet(e.ep);
                return 1'b1;
            end
            CMD_OUT_DONE: begin
                if (!ep_busy[e.ep] || ep_in[e.ep])
                    return 1'b0;
                r = next_out_receive(e.ep);
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic int unsigned draw_idle();
        return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 18) : 0;
    endfunction

    function automatic usb_evt_t rand_evt();
        usb_evt_t e;
        e.cmd    = 3'($urandom_range(0, 7));
        e.ep     = EP_W'($urandom_range(0, NUM_ENDPOINTS - 1));
        e.dir_in = 1'($urandom_range(0, 1));
        e.tlen   = LEN_W'($urandom_range(0, 65535));
        e.done   = DONE_W'($urandom_range(0, 1023));
        e.addr   = ADDR_W'($urandom_range(0, 127));
        return e;
    endfunction

    function automatic usb_evt_t mk_evt(logic [2:0] cmd, int unsigned ep, logic dir_in,
                                        int unsigned tlen, int unsigned done,
                                        int unsigned addr);
        usb_evt_t e;
        e.cmd    = cmd;
        e.ep     = EP_W'(ep);
        e.dir_in = dir_in;
        e.tlen   = LEN_W'(tlen);
        e.done   = DONE_W'(done);
        e.addr   = ADDR_W'(addr);
        return e;
    endfunction

    task automatic add_evt(usb_evt_t e);
        event_backlog.push_back(e);
        queued_count++;
    endtask

    function automatic int unsigned pick_len();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 0;
        if (r == 1)
            return MAX_PACKET * $urandom_range(1, 4);
        if (r == 2)
            return $urandom_range(1000, 65535);
        return $urandom_range(1, 200);
    endfunction

    // IN transfer with completions that mostly match the armed packet
    task automatic queue_in_transfer(logic [EP_W-1:0] ep, int unsigned len);
        usb_evt_t    e;
        int unsigned left;
        int unsigned pkt;
        int unsigned npk;
        e = rand_evt();
        e.cmd = CMD_START;
        e.ep = ep;
        e.dir_in = 1'b1;
        e.tlen = LEN_W'(len);
        add_evt(e);
        left = len;
        npk = 0;
        do begin
            pkt = (left > MAX_PACKET) ? MAX_PACKET : left;
            e = rand_evt();
            e.cmd = CMD_IN_DONE;
            e.ep = ep;
            e.done = DONE_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, pkt) : pkt);
            if ($urandom_range(0, 19) == 0)
                e.done = DONE_W'($urandom_range(0, 1023));
            add_evt(e);
            left = (e.done >= left) ? 0 : left - e.done;
            npk++;
            if ($urandom_range(0, 9) == 0)
                add_evt(rand_evt());
        end while (left > 0 && npk < 6);
    endtask

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        rst_n = 1'b0;
        events_if.valid = 1'b0;
        events_if.cmd = '0;
        events_if.endpoint = '0;
        events_if.direction_in = 1'b0;
        events_if.transfer_length = '0;
        events_if.bytes_done = '0;
        events_if.new_address = '0;
        actions_if.ready = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    initial begin
        #4_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    // request source; each accepted request goes through the predictor
    always @(posedge clk or negedge rst_n) begin : event_source
        usb_action_t r;
        usb_evt_t    nxt;
        if (!rst_n) begin
            events_if.valid <= 1'b0;
            events_if.cmd <= '0;
            events_if.endpoint <= '0;
            events_if.direction_in <= 1'b0;
            events_if.transfer_length <= '0;
            events_if.bytes_done <= '0;
            events_if.new_address <= '0;
            src_wait <= 0;
            events_taken <= 0;
            for (int i = 0; i < NUM_ENDPOINTS; i++) begin
                ep_size[i]  = '0;
                ep_count[i] = '0;
                ep_busy[i]  = 1'b0;
                ep_zlp[i]   = 1'b0;
                ep_in[i]    = 1'b0;
            end
            addr_pending = 1'b0;
            dev_addr = '0;
        end else begin
            if (events_if.valid && events_if.ready) begin
                if (sequence_event(offered, r))
                    pending_actions.push_back(r);
                events_taken <= events_taken + 1;
            end
            if (!events_if.valid || events_if.ready) begin
                if (src_wait > 0) begin
                    src_wait <= src_wait - 1;
                    events_if.valid <= 1'b0;
                end else if (event_backlog.size() > 0) begin
                    nxt = event_backlog.pop_front();
                    offered <= nxt;
                    events_if.cmd <= nxt.cmd;
                    events_if.endpoint <= nxt.ep;
                    events_if.direction_in <= nxt.dir_in;
                    events_if.transfer_length <= nxt.tlen;
                    events_if.bytes_done <= nxt.done;
                    events_if.new_address <= nxt.addr;
                    events_if.valid <= 1'b1;
                    src_wait <= draw_idle();
                end else begin
                    events_if.valid <= 1'b0;
                end
            end
        end
    end

    // one long back-pressure stretch early in the run to fill the core's queue
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            hold_left <= 0;
            hold_armed <= 1'b1;
        end else if (hold_armed && events_taken >= 60) begin
            hold_left <= HOLD_CYCLES;
            hold_armed <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge clk or negedge rst_n) begin : action_sink
        usb_action_t want;
        int unsigned w;
        if (!rst_n) begin
            actions_if.ready <= 1'b0;
            sink_wait <= 0;
        end else begin
            w = sink_wait;
            if (actions_if.valid && actions_if.ready) begin
                if (pending_actions.size() == 0) begin
                    fail_count = fail_count + 1;
                    if (fail_count <= 10)
                        $display("%0t: unexpected action %0d ep %0d off %0d len %0d adr %0d",
                                 $realtime, actions_if.action, actions_if.result_endpoint,
                                 actions_if.packet_offset, actions_if.packet_length,
                                 actions_if.address_value);
                end else begin
                    want = pending_actions.pop_front();
                    if (want.action !== actions_if.action
                        || want.ep !== actions_if.result_endpoint
                        || want.offset !== actions_if.packet_offset
                        || want.length !== actions_if.packet_length
                        || want.addr !== actions_if.address_value) begin
                        fail_count = fail_count + 1;
                        if (fail_count <= 10)
                            $display("%0t: action mismatch exp %0d/%0d/%0d/%0d/%0d",
                                     $realtime, want.action, want.ep, want.offset,
                                     want.length, want.addr,
                                     " got %0d/%0d/%0d/%0d/%0d", actions_if.action,
                                     actions_if.result_endpoint, actions_if.packet_offset,
                                     actions_if.packet_length, actions_if.address_value);
                    end
                end
                w = draw_idle();
            end
            if (hold_left > 0) begin
                actions_if.ready <= 1'b0;
            end else if (w > 0) begin
                actions_if.ready <= 1'b0;
                w = w - 1;
            end else begin
                actions_if.ready <= 1'b1;
            end
            sink_wait <= w;
        end
    end

    initial begin : stimulus
        usb_evt_t    e;
        int unsigned pick;
        int unsigned n;
        int unsigned directed;
        fail_count = 0;
        queued_count = 0;

        // zero-length IN, then the largest length with the largest byte count
        add_evt(mk_evt(CMD_START, 1, 1'b1, 0, 0, 0));
        add_evt(mk_evt(CMD_IN_DONE, 1, 1'b0, 0, 0, 0));
        add_evt(mk_evt(CMD_START, 2, 1'b1, 65535, 0, 0));
        add_evt(mk_evt(CMD_IN_DONE, 2, 1'b0, 0, 1023, 0));
        // OUT with data re-arms, zero-length OUT releases at once
        add_evt(mk_evt(CMD_START, 3, 1'b0, 100, 0, 0));
        add_evt(mk_evt(CMD_OUT_DONE, 3, 1'b0, 0, 0, 0));
        add_evt(mk_evt(CMD_START, 4, 1'b0, 0, 0, 0));
        add_evt(mk_evt(CMD_OUT_DONE, 4, 1'b0, 0, 0, 0));
        // completions on an idle endpoint and of the wrong direction
        add_evt(mk_evt(CMD_IN_DONE, 5, 1'b1, 0, 64, 0));
        add_evt(mk_evt(CMD_OUT_DONE, 2, 1'b0, 0, 0, 0));
        // set address through a nonzero endpoint field, status while ep0 busy
        add_evt(mk_evt(CMD_SET_ADDR, 7, 1'b0, 0, 0, 127));
        add_evt(mk_evt(CMD_STATUS, 0, 1'b0, 0, 0, 0));
        add_evt(mk_evt(CMD_IN_DONE, 0, 1'b0, 0, 0, 0));
        // pending address of zero completes plainly
        add_evt(mk_evt(CMD_SET_ADDR, 0, 1'b0, 0, 0, 0));
        add_evt(mk_evt(CMD_IN_DONE, 0, 1'b0, 0, 0, 0));
        // control read ending in the OUT status stage
        add_evt(mk_evt(CMD_START, 0, 1'b1, 18, 0, 0));
        add_evt(mk_evt(CMD_IN_DONE, 0, 1'b0, 0, 18, 0));
        add_evt(mk_evt(CMD_STATUS, 3, 1'b1, 0, 0, 0));
        add_evt(mk_evt(CMD_IN_DONE, 0, 1'b0, 0, 0, 0));
        // restart as OUT keeps the IN direction
        add_evt(mk_evt(CMD_START, 6, 1'b1, 10, 0, 0));
        add_evt(mk_evt(CMD_START, 6, 1'b0, 5, 0, 0));
        add_evt(mk_evt(CMD_OUT_DONE, 6, 1'b0, 0, 0, 0));
        add_evt(mk_evt(CMD_IN_DONE, 6, 1'b0, 0, 5, 0));
        // bus reset drops a pending address and the ep0 transfer
        add_evt(mk_evt(CMD_SET_ADDR, 0, 1'b0, 0, 0, 'h55));
        add_evt(mk_evt(CMD_BUS_RESET, 0, 1'b0, 0, 0, 0));
        add_evt(mk_evt(CMD_IN_DONE, 0, 1'b0, 0, 0, 0));
        add_evt(mk_evt(CMD_RSVD_A, 1, 1'b1, 65535, 1023, 127));
        add_evt(mk_evt(CMD_RSVD_B, 2, 1'b0, 0, 0, 0));
        directed = queued_count;

        while (queued_count < directed + RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                queue_in_transfer(EP_W'($urandom_range(0, NUM_ENDPOINTS - 1)), pick_len());
            end else if (pick < 45) begin
                e = rand_evt();
                e.cmd = CMD_START;
                e.dir_in = 1'b0;
                if ($urandom_range(0, 3) == 0)
                    e.tlen = '0;
                add_evt(e);
                n = $urandom_range(0, 3);
                repeat (n) begin
                    e.cmd = CMD_OUT_DONE;
                    e.tlen = LEN_W'($urandom_range(0, 65535));
                    add_evt(e);
                end
            end else if (pick < 60) begin
                e = rand_evt();
                e.cmd = CMD_SET_ADDR;
                if ($urandom_range(0, 4) == 0)
                    e.addr = '0;
                add_evt(e);
                e = rand_evt();
                e.cmd = CMD_IN_DONE;
                e.ep = '0;
                if ($urandom_range(0, 3) != 0)
                    e.done = '0;
                add_evt(e);
            end else if (pick < 70) begin
                e = rand_evt();
                e.cmd = CMD_STATUS;
                add_evt(e);
                e = rand_evt();
                e.cmd = CMD_IN_DONE;
                e.ep = '0;
                add_evt(e);
            end else if (pick < 80) begin
                queue_in_transfer('0, $urandom_range(1, 300));
                if ($urandom_range(0, 1) == 0) begin
                    e = rand_evt();
                    e.cmd = CMD_OUT_DONE;
                    e.ep = '0;
                    add_evt(e);
                end
            end else if (pick < 88) begin
                e = rand_evt();
                e.cmd = CMD_BUS_RESET;
                add_evt(e);
            end else begin
                add_evt(rand_evt());
            end
        end

        @(posedge rst_n);
        while (event_backlog.size() > 0 || events_if.valid)
            @(posedge clk);
        while (pending_actions.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
